// File: rtl/mbhq_pkg.sv
// Shared constants and types for the multi-button hold qualifier.
// Used by the lane, merge and top-level modules; depends on nothing.
`default_nettype none

package mbhq_pkg;

   localparam int BUTTON_COUNT  = 8;     // buttons scanned, 1 to 8
   localparam int PIN_COUNT     = 8;     // pins carried by a scan word
   localparam int TIME_W        = 32;
   localparam int DELAY_W       = 24;
   localparam int BTN_NUM_W     = 3;
   localparam int MAX_RESULTS   = 8;     // toggle words per scan at most
   localparam int RES_CNT_W     = $clog2(MAX_RESULTS);
   localparam int REQ_DATA_W    = 40;    // pins + time, whole bytes
   localparam int RSP_DATA_W    = 8;     // button number, padded to a byte

   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(50000);

   // Per-scan broadcast from the top level to every lane.
   typedef struct packed {
      logic              accept;
      logic [TIME_W-1:0] scan_time;
      logic [DELAY_W-1:0] delay;
   } lane_ctl_type;

endpackage

`default_nettype wire

// File: rtl/multi_button_hold_qualifier.sv
// Top level of the multi-button hold qualifier: delay register, one lane per
// button and the merge stage. Depends on mbhq_pkg, mbhq_lane and mbhq_merge.
//
// Usage: each req word is one scan of eight active-low button pins with a
// 32-bit microsecond timestamp. All lanes update their marks in the cycle the
// word is accepted; a button held and not yet fired for at least the
// debounce delay yields one rsp word carrying its number. The words of one
// scan leave in ascending button order, one per cycle while rsp_tready is
// high, and the last one has rsp_tlast set. A scan that qualifies no button
// produces no word. The first word of a scan is registered in cur, loaded
// from the merge buffer when a run was still being sent. Throughput: a scan
// is taken every cycle while the merge stage has room; a scan with n
// qualifying buttons holds the output for n words. One scan can wait in the
// merge buffer while another is sent, so req_tready drops only when both
// are occupied. A stalled rsp word holds. Reset clears all marks, empties the
// merge stage and sets the delay to 50000 us. The delay register is to be
// written by the user via csr_wr_en only while idle; unchecked by the block.
`default_nettype none

module multi_button_hold_qualifier (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [7:0] pin_levels, [39:8] scan_time
   input  wire logic [mbhq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [2:0] button_number, [7:3] zero
   output logic [mbhq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   input  wire logic                   csr_wr_en,
   input  wire logic [mbhq_pkg::DELAY_W-1:0] csr_wr_data
);
   import mbhq_pkg::*;

   logic [DELAY_W-1:0]      delay_ff, delay_in;
   logic [PIN_COUNT-1:0]    pin_levels;
   logic [BUTTON_COUNT-1:0] fire_mask;
   logic [BTN_NUM_W-1:0]    out_number;
   lane_ctl_type            ctl;

   assign pin_levels = req_tdata[PIN_COUNT-1:0];
   assign delay_in   = csr_wr_en ? csr_wr_data : delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else begin
         delay_ff <= delay_in;
      end
   end

   assign ctl.accept    = req_tvalid && req_tready;
   assign ctl.scan_time = req_tdata[PIN_COUNT +: TIME_W];
   assign ctl.delay     = delay_ff;

   for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
      logic pin_low;
      // Buttons beyond the scanned pins always read as pressed.
      if (b < PIN_COUNT) begin : g_pin
         assign pin_low = !pin_levels[b];
      end else begin : g_nopin
         assign pin_low = 1'b1;
      end
      mbhq_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .pin_low (pin_low),
         .fire    (fire_mask[b])
      );
   end

   mbhq_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .scan_accept (ctl.accept),
      .fire_mask   (fire_mask),
      .scan_ready  (req_tready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_number  (out_number),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W-BTN_NUM_W){1'b0}}, out_number};

endmodule

`default_nettype wire

// File: rtl/mbhq_lane.sv
// One button lane: held and fired marks, press start time, hold qualification.
// Depends on mbhq_pkg.
`default_nettype none

module mbhq_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mbhq_pkg::lane_ctl_type ctl,
   input  wire logic                 pin_low,
   output logic                      fire
);
   import mbhq_pkg::*;

   logic              held_ff, held_in;
   logic              fired_ff, fired_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] held_time;

   // Held time wraps modulo 2^32, as the timestamp does.
   assign held_time = ctl.scan_time - start_ff;
   assign fire = ctl.accept && pin_low && held_ff && !fired_ff &&
                 (held_time >= {{(TIME_W-DELAY_W){1'b0}}, ctl.delay});

   always_comb begin
      held_in  = held_ff;
      fired_in = fired_ff;
      start_in = start_ff;
      if (ctl.accept) begin
         if (!pin_low) begin
            held_in  = 1'b0;
            fired_in = 1'b0;
         end else if (!held_ff) begin
            held_in  = 1'b1;
            fired_in = 1'b0;
            start_in = ctl.scan_time;
         end else if (fire) begin
            fired_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         fired_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         fired_ff <= fired_in;
      end
      start_ff <= start_in;
   end

endmodule

`default_nettype wire

// File: rtl/mbhq_merge.sv
// Merge stage: buffers the fire masks of the lanes and sends one toggle word
// per set bit, lowest button first. Depends on mbhq_pkg.
`default_nettype none

module mbhq_merge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    scan_accept,
   input  wire logic [mbhq_pkg::BUTTON_COUNT-1:0] fire_mask,
   output logic                         scan_ready,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [mbhq_pkg::BTN_NUM_W-1:0] out_number,
   output logic                         out_last
);
   import mbhq_pkg::*;

   logic [BUTTON_COUNT-1:0] cur_ff, cur_in;
   logic [BUTTON_COUNT-1:0] pend_ff, pend_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [RES_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [BUTTON_COUNT-1:0] low_bit;
   logic                    new_valid;
   logic                    out_take;
   logic                    advance;

   assign low_bit = cur_ff & (~cur_ff + BUTTON_COUNT'(1));

   always_comb begin
      out_number = '0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         if (low_bit[b]) out_number = out_number | BTN_NUM_W'(b);
      end
   end

   // A scan ends at its highest set bit, or when the per-scan cap is reached.
   assign out_valid  = (cur_ff != '0);
   assign out_last   = ((cur_ff & ~low_bit) == '0) ||
                       (cnt_ff == RES_CNT_W'(MAX_RESULTS - 1));
   assign out_take   = out_valid && out_ready;
   assign advance    = !out_valid || (out_take && out_last);
   assign new_valid  = scan_accept && (fire_mask != '0);
   assign scan_ready = !pend_valid_ff;

   always_comb begin
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cnt_in        = cnt_ff;
      if (advance) begin
         cnt_in = '0;
         if (pend_valid_ff) begin
            cur_in        = pend_ff;
            pend_in       = fire_mask;
            pend_valid_in = new_valid;
         end else begin
            cur_in        = new_valid ? fire_mask : '0;
            pend_valid_in = 1'b0;
         end
      end else begin
         if (out_take) begin
            cur_in = cur_ff & ~low_bit;
            cnt_in = cnt_ff + RES_CNT_W'(1);
         end
         if (new_valid) begin
            pend_in       = fire_mask;
            pend_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         cur_ff        <= cur_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
      end
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

// File: rtl/mbhq_checker.sv
// Port-level checks for the multi-button hold qualifier, bound to its top.
// Depends on mbhq_pkg and multi_button_hold_qualifier.
`default_nettype none

module mbhq_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tready,
   input  wire logic rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic [mbhq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic rsp_tlast
);
   import mbhq_pkg::*;

   // A stalled word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // Reset leaves the output empty and the input open.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // Within one scan the next word follows at once with a higher button.
   a_ascend: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[BTN_NUM_W-1:0] > $past(rsp_tdata[BTN_NUM_W-1:0])))
      else $error("scan run broken or out of order");

   // The merge buffer is only occupied while a run is being sent.
   a_buffer_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with nothing to send");

endmodule

bind multi_button_hold_qualifier mbhq_checker u_mbhq_checker (.*);

`default_nettype wire
